// ===== hw/rtl/prce_pkg.sv =====
// Shared types and constants for the probe request channel extractor.
`default_nettype none

package prce_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES - 1);

    localparam int LEN_W  = 12;
    localparam int DATA_W = 8;
    localparam int CHAN_W = 4;

    localparam logic [LEN_W-1:0]  HDR_BYTES     = LEN_W'(24);
    localparam logic [LEN_W-1:0]  FCS_BYTES     = LEN_W'(4);
    localparam logic [DATA_W-1:0] DS_PARAM_ID   = DATA_W'(3);
    localparam logic [DATA_W-1:0] FC_TYPE_MASK  = 8'hFC;
    localparam logic [DATA_W-1:0] FC_PROBE_REQ  = 8'h40;
    localparam logic [DATA_W-1:0] CHAN_MIN      = DATA_W'(1);
    localparam logic [DATA_W-1:0] CHAN_MAX      = DATA_W'(14);
    localparam logic [CHAN_W-1:0] CHAN_RESET    = CHAN_W'(5);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_LEN,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              start_of_frame;
        logic              end_of_frame;
        logic [LEN_W-1:0]  total_len;
    } t_req_in;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              updated;
    } t_result;

    typedef struct packed {
        logic    fire;
        t_result res;
    } t_parse_out;

endpackage

`default_nettype wire

// ===== hw/rtl/prce_parser.sv =====
// Per-byte information element walker holding the frame and channel state.
`default_nettype none

module prce_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire prce_pkg::t_req_in    i_req,
    output prce_pkg::t_parse_out      o_pout
);

    logic [prce_pkg::POS_W-1:0]  r_pos,    n_pos;
    prce_pkg::t_phase            r_phase,  n_phase;
    logic [prce_pkg::DATA_W-1:0] r_id,     n_id;
    logic [prce_pkg::DATA_W-1:0] r_left,   n_left;
    logic [prce_pkg::DATA_W-1:0] r_elen,   n_elen;
    logic                        r_qual,   n_qual;
    logic [prce_pkg::CHAN_W-1:0] r_chan,   n_chan;
    logic                        r_set,    n_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= prce_pkg::PH_HEADER;
            r_id    <= '0;
            r_left  <= '0;
            r_elen  <= '0;
            r_qual  <= 1'b0;
            r_chan  <= prce_pkg::CHAN_RESET;
            r_set   <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_id    <= n_id;
            r_left  <= n_left;
            r_elen  <= n_elen;
            r_qual  <= n_qual;
            r_chan  <= n_chan;
            r_set   <= n_set;
        end
    end

    logic [prce_pkg::POS_W-1:0]  c_pos;
    logic [prce_pkg::LEN_W-1:0]  limit;
    logic [prce_pkg::LEN_W:0]    elem_end;
    logic [prce_pkg::DATA_W-1:0] d;
    logic [prce_pkg::DATA_W-1:0] left_dec;

    always_comb begin
        d = i_req.data;

        // start flag drops whatever frame was in progress
        c_pos   = r_pos;
        n_phase = r_phase;
        n_id    = r_id;
        n_left  = r_left;
        n_elen  = r_elen;
        n_qual  = r_qual;
        n_set   = r_set;
        n_chan  = r_chan;
        if (i_req.start_of_frame) begin
            c_pos   = '0;
            n_phase = prce_pkg::PH_HEADER;
            n_id    = '0;
            n_left  = '0;
            n_elen  = '0;
            n_qual  = 1'b0;
            n_set   = 1'b0;
        end

        limit = (i_req.total_len > prce_pkg::FCS_BYTES) ?
                (i_req.total_len - prce_pkg::FCS_BYTES) : '0;
        elem_end = {1'b0, prce_pkg::LEN_W'(c_pos)} + (prce_pkg::LEN_W+1)'(1)
                 + (prce_pkg::LEN_W+1)'(d);
        left_dec = n_left - prce_pkg::DATA_W'(1);

        case (n_phase)
            prce_pkg::PH_HEADER: begin
                if (c_pos == '0) begin
                    n_qual = ((d & prce_pkg::FC_TYPE_MASK) == prce_pkg::FC_PROBE_REQ) &&
                             (i_req.total_len > (prce_pkg::HDR_BYTES + prce_pkg::FCS_BYTES));
                end
                if (prce_pkg::LEN_W'(c_pos) >= (prce_pkg::HDR_BYTES - prce_pkg::LEN_W'(1))) begin
                    n_phase = n_qual ? prce_pkg::PH_ID : prce_pkg::PH_DONE;
                end
            end
            prce_pkg::PH_ID: begin
                if (prce_pkg::LEN_W'(c_pos) >= limit) begin
                    n_phase = prce_pkg::PH_DONE;
                end else begin
                    n_id    = d;
                    n_phase = prce_pkg::PH_LEN;
                end
            end
            prce_pkg::PH_LEN: begin
                if (prce_pkg::LEN_W'(c_pos) >= limit) begin
                    n_phase = prce_pkg::PH_DONE;
                end else if (elem_end > {1'b0, limit}) begin
                    // element would run past the FCS
                    n_phase = prce_pkg::PH_DONE;
                end else begin
                    n_elen  = d;
                    n_left  = d;
                    n_phase = (d == '0) ? prce_pkg::PH_ID : prce_pkg::PH_BODY;
                end
            end
            prce_pkg::PH_BODY: begin
                if (prce_pkg::LEN_W'(c_pos) >= limit) begin
                    n_phase = prce_pkg::PH_DONE;
                end else if ((n_left == n_elen) && (n_id == prce_pkg::DS_PARAM_ID) &&
                             (n_elen == prce_pkg::DATA_W'(1)) &&
                             (d >= prce_pkg::CHAN_MIN) && (d <= prce_pkg::CHAN_MAX)) begin
                    n_chan  = prce_pkg::CHAN_W'(d);
                    n_set   = 1'b1;
                    n_phase = prce_pkg::PH_DONE;
                end else begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = prce_pkg::PH_ID;
                    end
                end
            end
            default: begin
                n_phase = prce_pkg::PH_DONE;
            end
        endcase

        n_pos = (c_pos < prce_pkg::POS_MAX) ? (c_pos + prce_pkg::POS_W'(1)) : c_pos;

        o_pout.fire        = i_accept && i_req.end_of_frame;
        o_pout.res.channel = n_chan;
        o_pout.res.updated = n_set;

        if (i_req.end_of_frame) begin
            n_pos   = '0;
            n_phase = prce_pkg::PH_HEADER;
            n_id    = '0;
            n_left  = '0;
            n_elen  = '0;
            n_qual  = 1'b0;
            n_set   = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/prce_out_reg.sv =====
// Result register that decouples the output handshake from the parser.
`default_nettype none

module prce_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire prce_pkg::t_parse_out i_pout,
    input  wire logic                 i_out_ready,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output prce_pkg::t_result         o_out_res
);

    logic              r_valid, n_valid;
    prce_pkg::t_result r_res;

    // a new byte may enter whenever the held result leaves this cycle
    assign o_in_ready = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_pout.fire) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pout.fire) begin
            r_res <= i_pout.res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_res   = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/probe_request_channel_extractor_core.sv =====
// Top level of the probe request channel extractor.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_req  (one frame byte)
//  out     | o_out_valid | i_out_ready | o_out_res (channel, updated)
//
// One byte is taken each cycle o_in_ready is high; parse state updates on accept.
// A result appears in the output register the cycle after an end-of-frame byte.
// Reset (synchronous, active low) sets the scan channel to 5 and clears the walk.
// While a result waits, bytes keep flowing if the same cycle drains it;
// otherwise o_in_ready drops until the result is taken.
`default_nettype none

module probe_request_channel_extractor_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire prce_pkg::t_req_in  i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output prce_pkg::t_result       o_out_res
);

    logic                 accept;
    prce_pkg::t_parse_out pout;

    assign accept = i_in_valid && o_in_ready;

    prce_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_pout   (pout)
    );

    prce_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pout      (pout),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire
